[src/rva_pkg.sv]
// ----------------------------------------------------------------------------
// rva_pkg - running value aggregator shared definitions
// Operator codes, operation codes and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
package rva_pkg;

	localparam int DataW    = 64;
	localparam int OpW      = 3;
	localparam int DivSteps = DataW;
	localparam int StepW    = $clog2(DivSteps);

	// aggregate operator register codes
	localparam logic [OpW-1:0] OP_NONE  = 3'd0;
	localparam logic [OpW-1:0] OP_COUNT = 3'd1;
	localparam logic [OpW-1:0] OP_SUM   = 3'd2;
	localparam logic [OpW-1:0] OP_AVG   = 3'd3;
	localparam logic [OpW-1:0] OP_FIRST = 3'd4;
	localparam logic [OpW-1:0] OP_LAST  = 3'd5;

	// input beat operation codes
	localparam logic OPER_UPDATE = 1'b0;
	localparam logic OPER_READ   = 1'b1;

	typedef struct packed {
		logic upd_add;    // add sample, count it
		logic upd_store;  // overwrite with sample, count it
		logic rd_count;   // emit count, clear
		logic rd_acc;     // emit accumulator, clear
		logic rd_none;    // emit not-ok result, keep state
		logic div_start;  // load divider, clear
		logic div_step;   // one quotient bit
		logic div_fin;    // sign-fix quotient, emit
	} rva_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic div_last;
		logic out_hold;
	} rva_stat_t;

endpackage

[src/rva_if.sv]
// ----------------------------------------------------------------------------
// rva_if - running value aggregator channels
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface rva_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [63:0] sample_value;

	modport source (output valid, output operation, output sample_value, input ready);
	modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

interface rva_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] aggregate_result;
	logic               result_ok;

	modport source (output valid, output aggregate_result, output result_ok, input ready);
	modport sink   (input valid, input aggregate_result, input result_ok, output ready);
endinterface

[src/rva_ctrl.sv]
// ----------------------------------------------------------------------------
// rva_ctrl - aggregator controller
// Holds the operator register, owns input ready and sequences the divider.
// ----------------------------------------------------------------------------
module rva_ctrl import rva_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [OpW-1:0] cfg_wr_data,
	input  logic           in_valid,
	input  logic           in_operation,
	output logic           in_ready,
	input  rva_stat_t      stat,
	output rva_cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]     state_q;
	logic [1:0]     state_nxt;
	logic [OpW-1:0] op_q;
	logic           accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_NONE;
		end else if (cfg_wr_en) begin
			op_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// a read needs the result register free (or draining this cycle)
	assign in_ready = (state_q == ST_IDLE) &&
	                  ((in_operation == OPER_UPDATE) || !stat.out_hold);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_operation == OPER_UPDATE)) begin
					if (op_q inside {OP_COUNT, OP_SUM, OP_AVG}) begin
						cmd.upd_add = 1'b1;
					end else if (op_q == OP_FIRST) begin
						cmd.upd_store = stat.count_zero;
					end else if (op_q == OP_LAST) begin
						cmd.upd_store = 1'b1;
					end
				end else if (accept) begin
					case (op_q)
						OP_COUNT: begin
							cmd.rd_count = 1'b1;
						end
						OP_SUM, OP_FIRST, OP_LAST: begin
							cmd.rd_acc = 1'b1;
						end
						OP_AVG: begin
							cmd.div_start = 1'b1;
							state_nxt     = ST_DIV;
						end
						default: begin
							cmd.rd_none = 1'b1;
						end
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.div_fin = 1'b1;
				state_nxt   = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

[src/rva_dpath.sv]
// ----------------------------------------------------------------------------
// rva_dpath - aggregator datapath
// Accumulator, count, radix-2 restoring divider and result register.
// ----------------------------------------------------------------------------
module rva_dpath import rva_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rva_cmd_t                cmd,
	input  logic signed [DataW-1:0] sample_value,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic signed [DataW-1:0] aggregate_result,
	output logic                    result_ok,
	output rva_stat_t               stat
);

	logic [DataW-1:0] acc_q;
	logic [DataW-1:0] cnt_q;
	logic [DataW-1:0] rem_q;
	logic [DataW-1:0] quo_q;
	logic [DataW-1:0] dvs_q;
	logic             neg_q;
	logic             zero_q;
	logic [StepW-1:0] step_q;
	logic             out_valid_q;
	logic [DataW-1:0] res_q;
	logic             ok_q;

	logic [DataW:0]   rem_sh;
	logic [DataW:0]   diff;
	logic [DataW-1:0] quo_fix;
	logic             rd_clear;

	assign rd_clear = cmd.rd_count || cmd.rd_acc || cmd.div_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.upd_add) begin
			acc_q <= acc_q + DataW'(sample_value);
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.upd_store) begin
			acc_q <= DataW'(sample_value);
			cnt_q <= cnt_q + 1'b1;
		end else if (rd_clear) begin
			acc_q <= '0;
			cnt_q <= '0;
		end
	end

	// one quotient bit per step on magnitudes
	assign rem_sh = {rem_q, quo_q[DataW-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q  <= acc_q[DataW-1] ? (~acc_q + 1'b1) : acc_q;
			dvs_q  <= cnt_q[DataW-1] ? (~cnt_q + 1'b1) : cnt_q;
			rem_q  <= '0;
			neg_q  <= acc_q[DataW-1] ^ cnt_q[DataW-1];
			zero_q <= (cnt_q == '0);
		end else if (cmd.div_step) begin
			if (!diff[DataW]) begin
				rem_q <= diff[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_start) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	assign quo_fix = zero_q ? '0 : (neg_q ? (~quo_q + 1'b1) : quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_count || cmd.rd_acc || cmd.rd_none || cmd.div_fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_count) begin
			res_q <= cnt_q;
			ok_q  <= 1'b1;
		end else if (cmd.rd_acc) begin
			res_q <= acc_q;
			ok_q  <= 1'b1;
		end else if (cmd.rd_none) begin
			res_q <= '0;
			ok_q  <= 1'b0;
		end else if (cmd.div_fin) begin
			res_q <= quo_fix;
			ok_q  <= 1'b1;
		end
	end

	assign out_valid        = out_valid_q;
	assign aggregate_result = res_q;
	assign result_ok        = ok_q;

	assign stat.count_zero = (cnt_q == '0);
	assign stat.div_last   = (step_q == StepW'(DivSteps - 1));
	assign stat.out_hold   = out_valid_q && !out_ready;

endmodule

[src/running_value_aggregator_core.sv]
// ----------------------------------------------------------------------------
// running_value_aggregator_core - running count/sum/average/first/last
// Keeps a 64-bit signed accumulator and a 64-bit count, folds update beats
// in and answers reads with the selected aggregate, then clears (unless none).
// ----------------------------------------------------------------------------
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+--------------------------------------
//  in_ch     | in  | valid/ready  | operation, sample_value
//  out_ch    | out | valid/ready  | aggregate_result, result_ok
//  cfg       | in  | cfg_wr_en    | cfg_wr_data (aggregate operator)
//
//  Update beats are accepted back to back while no division runs, also
//  while a result beat waits on out_ch.
//  Reads of count, sum, first or last are answered in the cycle after they
//  are taken; a read under average runs a load, 64 radix-2 divider steps and
//  a sign fix in the one-bit-per-cycle restoring divider. in_ch.ready is low meanwhile.
//  A read is held off while the single result register is occupied and
//  not being drained.
//  arst_n clears accumulator, count, operator (to none) and all control.
// ----------------------------------------------------------------------------
module running_value_aggregator_core import rva_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [OpW-1:0] cfg_wr_data,
	rva_in_if.sink         in_ch,
	rva_out_if.source      out_ch
);

	rva_cmd_t  cmd;
	rva_stat_t stat;

	// controller: operator register, ready, divider sequencing
	rva_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_ch.valid),
		.in_operation (in_ch.operation),
		.in_ready     (in_ch.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// datapath: state, divider and result register
	rva_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sample_value     (in_ch.sample_value),
		.out_ready        (out_ch.ready),
		.out_valid        (out_ch.valid),
		.aggregate_result (out_ch.aggregate_result),
		.result_ok        (out_ch.result_ok),
		.stat             (stat)
	);

endmodule

[src/rva_checker.sv]
// ----------------------------------------------------------------------------
// rva_checker - aggregator port checks
// Temporal checks on the core's channels, bound to the top level.
// ----------------------------------------------------------------------------
module rva_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_result,
	input logic        out_ok
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_ok))
		else $error("result beat changed under stall");

	// a not-ok result carries zero
	a_not_ok_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ok |-> out_result == 64'd0)
		else $error("not-ok result is non-zero");

	// a read either answers next cycle or starts the divider
	a_read_reply: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_operation |=> out_valid || !in_ready)
		else $error("read neither answered nor dividing");

	// a new result only follows a read or the end of a division
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready || (in_valid && in_operation))
		|| $past(!arst_n))
		else $error("result beat without a read");

endmodule

bind running_value_aggregator_core rva_checker u_rva_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_operation (in_ch.operation),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_result   (out_ch.aggregate_result),
	.out_ok       (out_ch.result_ok)
);

[verif/rva_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rva_scoreboard - result predictor and scoreboard for the aggregator
// Watches the configuration port and both channels, keeps its own copy of
// the accumulator, count and operator, and compares every result beat with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module rva_scoreboard import rva_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [OpW-1:0] cfg_wr_data,
	rva_in_if              in_ch,
	rva_out_if             out_ch,
	output int             mismatch_total,
	output int             results_outstanding
);

	typedef struct packed {
		logic signed [DataW-1:0] value;
		logic                    ok;
	} agg_result_t;

	agg_result_t      predicted_results[$];
	agg_result_t      oldest;
	logic [OpW-1:0]   agg_op;
	logic [DataW-1:0] acc_value;
	logic [DataW-1:0] sample_cnt;

	initial mismatch_total = 0;

	task automatic report_mismatch(input string what);
		$display("%0t ns  mismatch: %s", $time, what);
		mismatch_total++;
	endtask

	// signed quotient on magnitudes, truncated toward zero; zero divisor gives 0
	function automatic logic [DataW-1:0] mean_trunc(input logic [DataW-1:0] total,
	                                                input logic [DataW-1:0] n);
		logic             neg_t;
		logic             neg_n;
		logic [DataW-1:0] mag_t;
		logic [DataW-1:0] mag_n;
		logic [DataW-1:0] quo;
		neg_t = total[DataW-1];
		neg_n = n[DataW-1];
		mag_t = neg_t ? -total : total;
		mag_n = neg_n ? -n : n;
		if (mag_n == '0)
			return '0;
		quo = mag_t / mag_n;
		return (neg_t ^ neg_n) ? -quo : quo;
	endfunction

	task automatic fold_beat(input logic oper, input logic [DataW-1:0] sample);
		agg_result_t res;
		if (oper == OPER_UPDATE) begin
			case (agg_op)
				OP_COUNT, OP_SUM, OP_AVG: begin
					acc_value  = acc_value + sample;
					sample_cnt = sample_cnt + 1'b1;
				end
				OP_FIRST: begin
					if (sample_cnt == '0) begin
						acc_value  = sample;
						sample_cnt = sample_cnt + 1'b1;
					end
				end
				OP_LAST: begin
					acc_value  = sample;
					sample_cnt = sample_cnt + 1'b1;
				end
				default: ;
			endcase
		end else begin
			res.ok = 1'b1;
			case (agg_op)
				OP_COUNT:                  res.value = sample_cnt;
				OP_SUM, OP_FIRST, OP_LAST: res.value = acc_value;
				OP_AVG:                    res.value = mean_trunc(acc_value, sample_cnt);
				default: begin
					res.value = '0;
					res.ok    = 1'b0;
				end
			endcase
			// a read under no operator leaves the state alone
			if (res.ok) begin
				acc_value  = '0;
				sample_cnt = '0;
			end
			predicted_results.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agg_op     = OP_NONE;
			acc_value  = '0;
			sample_cnt = '0;
			predicted_results.delete();
			results_outstanding <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch($sformatf("result beat value %0d ok %0b with none pending",
					                          out_ch.aggregate_result, out_ch.result_ok));
				end else begin
					oldest = predicted_results.pop_front();
					if (out_ch.aggregate_result !== oldest.value)
						report_mismatch($sformatf("aggregate_result %0d, predicted %0d",
						                          out_ch.aggregate_result, oldest.value));
					if (out_ch.result_ok !== oldest.ok)
						report_mismatch($sformatf("result_ok %0b, predicted %0b",
						                          out_ch.result_ok, oldest.ok));
				end
			end
			if (cfg_wr_en)
				agg_op = cfg_wr_data;
			if (in_ch.valid && in_ch.ready)
				fold_beat(in_ch.operation, in_ch.sample_value);
			results_outstanding <= predicted_results.size();
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - running value aggregator testbench
// Drives operator writes, update and read beats into the core, drains the
// result channel with random back-pressure, and leaves prediction and
// comparison to rva_scoreboard. Directed corner beats first, then random
// update/read sequences under three idling regimes.
// ----------------------------------------------------------------------------
module tb_top import rva_pkg::*; ();

	// undefined operator codes, which must behave as "none"
	localparam logic [OpW-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OpW-1:0] OP_RSVD7 = 3'd7;

	localparam logic [DataW-1:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [DataW-1:0] S64_MIN = 64'h8000_0000_0000_0000;

	// covers the divider work of an average read, with some margin
	localparam int DRAIN_CYCLES  = 80;
	localparam int LONG_HOLD     = 400;
	localparam int SEGMENTS      = 8;
	localparam int SEGMENT_BEATS = 80;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           cfg_wr_en;
	logic [OpW-1:0] cfg_wr_data;

	int             mismatch_total;
	int             results_outstanding;

	// idling percentages, changed per phase by the stimulus process
	int             send_idle = 18;
	int             recv_idle = 51;

	// long receiver hold-off, requested by stimulus, counted by the drain side
	logic           pressure_on   = 1'b0;
	logic           long_hold_done = 1'b0;
	int             hold_count    = 0;

	rva_in_if  in_ch ();
	rva_out_if out_ch ();

	running_value_aggregator_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	rva_scoreboard u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.in_ch               (in_ch),
		.out_ch              (out_ch),
		.mismatch_total      (mismatch_total),
		.results_outstanding (results_outstanding)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop. The slowest legal run (every beat an average read, every
	// result stalled by the receiver) is well under a fifth of this.
	initial begin
		#40_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: random ready, except for one long hold-off once pressure
	// is requested, so the result register stays full and in_ch stalls.
	always @(posedge clk) begin
		if (pressure_on && !long_hold_done) begin
			out_ch.ready <= 1'b0;
			hold_count   <= hold_count + 1;
			if (hold_count == LONG_HOLD - 1)
				long_hold_done <= 1'b1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// One beat on in_ch; returns at the edge where it is taken. Random gaps
	// go in front of the beat, so valid is never dropped and raised in the
	// same step.
	task automatic send_beat(input logic oper, input logic [DataW-1:0] sample);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.operation    <= oper;
		in_ch.sample_value <= sample;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Quiesce: stop offering, wait for every predicted result to drain, then
	// let the divider or a last update finish.
	task automatic quiesce();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// operator register write, only ever with the core idle
	task automatic write_op(input logic [OpW-1:0] code);
		quiesce();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= code;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// sample mix: extremes, zero, minus one, small values and full-width noise
	function automatic logic [DataW-1:0] pick_sample();
		case ($urandom_range(9))
			0:       return S64_MAX;
			1:       return S64_MIN;
			2:       return '0;
			3:       return '1;
			4:       return DataW'($signed($urandom_range(200)) - 100);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Mostly well-formed runs of updates closed by a read; some stray beats.
	task automatic random_segment(input int beats, input int max_run);
		int sent;
		int run;
		sent = 0;
		while (sent < beats) begin
			if ($urandom_range(9) == 0) begin
				send_beat(1'($urandom_range(1)), pick_sample());
				sent++;
			end else begin
				run = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(max_run);
				repeat (run) begin
					send_beat(OPER_UPDATE, pick_sample());
					sent++;
				end
				// sample on a read is ignored, but toggle it anyway
				send_beat(OPER_READ, {$urandom, $urandom});
				sent++;
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = OP_NONE;
		in_ch.valid        = 1'b0;
		in_ch.operation    = OPER_UPDATE;
		in_ch.sample_value = '0;
		out_ch.ready       = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed corners ----
		// no operator: update ignored, read gives not-ok and keeps state
		write_op(OP_NONE);
		send_beat(OPER_UPDATE, S64_MAX);
		send_beat(OPER_READ, '0);

		write_op(OP_COUNT);
		send_beat(OPER_UPDATE, S64_MIN);
		send_beat(OPER_UPDATE, '0);
		send_beat(OPER_READ, '1);

		// sum wraps at 64 bits
		write_op(OP_SUM);
		send_beat(OPER_UPDATE, S64_MAX);
		send_beat(OPER_UPDATE, S64_MAX);
		send_beat(OPER_UPDATE, '1);
		send_beat(OPER_READ, S64_MAX);

		// average of nothing, truncation toward zero of a negative mean,
		// and the most negative value over one
		write_op(OP_AVG);
		send_beat(OPER_READ, '0);
		send_beat(OPER_UPDATE, -64'sd7);
		send_beat(OPER_UPDATE, 64'sd2);
		send_beat(OPER_READ, '0);
		send_beat(OPER_UPDATE, S64_MIN);
		send_beat(OPER_READ, '0);

		// first keeps the first sample only
		write_op(OP_FIRST);
		send_beat(OPER_UPDATE, 64'sd5);
		send_beat(OPER_UPDATE, S64_MIN);
		send_beat(OPER_READ, '0);

		// last overwrites; leave one sample behind for the operator change
		write_op(OP_LAST);
		send_beat(OPER_UPDATE, S64_MIN);
		send_beat(OPER_UPDATE, 64'sd7);
		send_beat(OPER_READ, '0);
		send_beat(OPER_UPDATE, 64'sd9);

		// undefined codes act as none and must not disturb the kept sample
		write_op(OP_RSVD6);
		send_beat(OPER_UPDATE, 64'sd3);
		send_beat(OPER_READ, '0);
		write_op(OP_RSVD7);
		send_beat(OPER_READ, '1);

		// operator change keeps state: sum now returns the kept sample
		write_op(OP_SUM);
		send_beat(OPER_READ, '0);

		// ---- random part, three idling regimes ----
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle = 18; recv_idle = 51; end
				1: begin send_idle = 51; recv_idle = 18; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				if (phase == 2 && seg == 0) begin
					// back-to-back reads against a stalled receiver
					write_op(OP_SUM);
					pressure_on = 1'b1;
					random_segment(SEGMENT_BEATS, 1);
					pressure_on = 1'b0;
				end else begin
					write_op(OpW'($urandom_range(7)));
					random_segment(SEGMENT_BEATS, 6);
				end
			end
		end

		quiesce();
		if (mismatch_total == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
